// File: rtl/radar_measurement_jacobian_core_macros.svh
// Assertion macros used by the checker file of the radar Jacobian core.
`ifndef RADAR_MEASUREMENT_JACOBIAN_CORE_MACROS_SVH
`define RADAR_MEASUREMENT_JACOBIAN_CORE_MACROS_SVH

// Same-cycle implication, held off while reset is low
`define RMJ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmj: same-cycle check failed");

// Next-cycle implication, held off while reset is low
`define RMJ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rmj: next-cycle check failed");

`endif

// File: rtl/rmj_pkg.sv
// ----------------------------------------------------------------------------
// rmj_pkg
// Widths, limits, field positions and the sideband record of the radar
// measurement Jacobian pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rmj_pkg;

  // Stream field and arithmetic widths
  localparam int FIELD_W  = 32;
  localparam int RAD_W    = 64;   // r2 = px^2 + py^2
  localparam int ROOT_W   = 32;   // floor(sqrt(r2))
  localparam int C_W      = 64;   // |vx*py - vy*px|
  localparam int PROD_W   = 96;   // |p| * |c| and r2 * r
  localparam int Q_W      = 32;   // quotient bits kept before clipping
  localparam int DIV_LAT  = Q_W + 2;

  localparam logic [Q_W-1:0] LIM_POS = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0] LIM_NEG = 32'h8000_0000;

  localparam logic [FIELD_W-1:0] MIN_RANGE_SQ_RST = 32'd7;

  // tuser bit positions of the result word
  localparam int TU_TOO_CLOSE = 0;
  localparam int TU_SAT       = 1;
  localparam int TUSER_W      = 2;

  // Values that ride along the square root stages
  typedef struct packed {
    logic [FIELD_W-1:0] apx;
    logic [FIELD_W-1:0] apy;
    logic               npx;
    logic               npy;
    logic [RAD_W-1:0]   r2;
    logic [C_W-1:0]     ac;
    logic               nc;
    logic               tc;
  } rmj_side_t;

endpackage

`default_nettype wire

// File: rtl/rmj_sqrt.sv
// ----------------------------------------------------------------------------
// rmj_sqrt
// Pipelined integer square root, one result bit per stage, with a sideband
// word and a valid bit carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module rmj_sqrt #(
  parameter int SB_W = 8
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic                      vld_i,
  input  wire logic [rmj_pkg::RAD_W-1:0] rad_i,
  input  wire logic [SB_W-1:0]           sb_i,
  output logic                           vld_o,
  output logic [rmj_pkg::ROOT_W-1:0]     root_o,
  output logic [SB_W-1:0]                sb_o
);
  import rmj_pkg::*;

  localparam int N     = ROOT_W;
  localparam int REM_W = ROOT_W + 2;

  logic [N-1:0]        vld_q;
  logic [RAD_W-1:0]    rad_q [N];
  logic [REM_W-1:0]    rem_q [N];
  logic [ROOT_W-1:0]   res_q [N];
  logic [SB_W-1:0]     sb_q  [N];

  for (genvar k = 0; k < N; k++) begin : g_st
    logic [RAD_W-1:0]   rad_in;
    logic [REM_W-1:0]   rem_in;
    logic [ROOT_W-1:0]  res_in;
    logic [SB_W-1:0]    sb_in;
    logic               v_in;
    logic [REM_W+1:0]   rem_sh;
    logic [REM_W+1:0]   trial;
    logic [REM_W+1:0]   diff;
    logic               ge;

    if (k == 0) begin : g_first
      assign rad_in = rad_i;
      assign rem_in = '0;
      assign res_in = '0;
      assign sb_in  = sb_i;
      assign v_in   = vld_i;
    end else begin : g_next
      assign rad_in = rad_q[k-1];
      assign rem_in = rem_q[k-1];
      assign res_in = res_q[k-1];
      assign sb_in  = sb_q[k-1];
      assign v_in   = vld_q[k-1];
    end

    // Bring down two radicand bits and try the next root bit
    assign rem_sh = {rem_in, rad_in[RAD_W-1 -: 2]};
    assign trial  = {2'b00, res_in, 2'b01};
    assign ge     = rem_sh >= trial;
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k] <= {rad_in[RAD_W-3:0], 2'b00};
        rem_q[k] <= ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
        res_q[k] <= {res_in[ROOT_W-2:0], ge};
        sb_q[k]  <= sb_in;
      end
    end
  end

  assign vld_o  = vld_q[N-1];
  assign root_o = res_q[N-1];
  assign sb_o   = sb_q[N-1];

endmodule

`default_nettype wire

// File: rtl/rmj_div.sv
// ----------------------------------------------------------------------------
// rmj_div
// Pipelined restoring divider for magnitudes, one quotient bit per stage,
// followed by signed clipping to the 32-bit range.
// ----------------------------------------------------------------------------
`default_nettype none

module rmj_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   en_i,
  input  wire logic [NUM_W-1:0]       num_i,
  input  wire logic [DEN_W-1:0]       den_i,
  input  wire logic                   neg_i,
  output logic [rmj_pkg::Q_W-1:0]     quo_o,
  output logic                        sat_o
);
  import rmj_pkg::*;

  localparam int EXT_W = NUM_W + DEN_W;
  localparam int HI_W  = EXT_W - Q_W;

  logic [EXT_W-1:0] ext;
  logic [HI_W-1:0]  hi;

  logic [DEN_W-1:0] s0_rem_q;
  logic [Q_W-1:0]   s0_lo_q;
  logic [DEN_W-1:0] s0_den_q;
  logic             s0_neg_q;
  logic             s0_ovf_q;

  logic [DEN_W-1:0] rem_q [Q_W];
  logic [Q_W-1:0]   lo_q  [Q_W];
  logic [Q_W-1:0]   quo_q [Q_W];
  logic [DEN_W-1:0] den_q [Q_W];
  logic             neg_q [Q_W];
  logic             ovf_q [Q_W];

  // Flag a quotient of 2^32 or more, seed the remainder with the high part
  assign ext = EXT_W'(num_i);
  assign hi  = ext[EXT_W-1:Q_W];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s0_rem_q <= hi[DEN_W-1:0];
      s0_lo_q  <= num_i[Q_W-1:0];
      s0_den_q <= den_i;
      s0_neg_q <= neg_i;
      s0_ovf_q <= hi >= HI_W'(den_i);
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_st
    logic [DEN_W-1:0] rem_in;
    logic [Q_W-1:0]   lo_in;
    logic [Q_W-1:0]   quo_in;
    logic [DEN_W-1:0] den_in;
    logic             neg_in;
    logic             ovf_in;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = s0_rem_q;
      assign lo_in  = s0_lo_q;
      assign quo_in = '0;
      assign den_in = s0_den_q;
      assign neg_in = s0_neg_q;
      assign ovf_in = s0_ovf_q;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign lo_in  = lo_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
      assign neg_in = neg_q[k-1];
      assign ovf_in = ovf_q[k-1];
    end

    // Shift in one numerator bit, subtract the divisor where it fits
    assign rem_sh = {rem_in, lo_in[Q_W-1]};
    assign ge     = rem_sh >= {1'b0, den_in};
    assign diff   = rem_sh - {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        lo_q[k]  <= {lo_in[Q_W-2:0], 1'b0};
        quo_q[k] <= {quo_in[Q_W-2:0], ge};
        den_q[k] <= den_in;
        neg_q[k] <= neg_in;
        ovf_q[k] <= ovf_in;
      end
    end
  end

  // Clip the magnitude to the signed range and apply the sign
  logic [Q_W-1:0] lim;
  logic           over;
  logic [Q_W-1:0] mag;

  assign lim  = neg_q[Q_W-1] ? LIM_NEG : LIM_POS;
  assign over = ovf_q[Q_W-1] || (quo_q[Q_W-1] > lim);
  assign mag  = over ? lim : quo_q[Q_W-1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_o <= neg_q[Q_W-1] ? (Q_W'(0) - mag) : mag;
      sat_o <= over;
    end
  end

endmodule

`default_nettype wire

// File: rtl/radar_measurement_jacobian_core.sv
// The pipeline holds 73 register stages between an accepted word and its result.
// Throughput: one track state per cycle; the pipeline moves as a whole and
// halts only while a finished result sits unread in the output register.
// The depth comes from the 32-stage square root and the 34-stage dividers.
// Reset clears all valid bits and loads min_range_squared with 7.
// ----------------------------------------------------------------------------
// radar_measurement_jacobian_core
// Radar range, bearing and range-rate Jacobian of a constant-velocity track,
// Q-format fixed point with saturated quotients and a too-close flag.
// ----------------------------------------------------------------------------
`default_nettype none

module radar_measurement_jacobian_core #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Configuration: min_range_squared
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [rmj_pkg::FIELD_W-1:0]     cfg_data_i,
  // Track state in
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // position_x, position_y, velocity_x, velocity_y
  input  wire logic [4*rmj_pkg::FIELD_W-1:0]   s_axis_tdata,
  // Jacobian out
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // range_by_px, range_by_py, bearing_by_px, bearing_by_py, rate_by_px,
  // rate_by_py
  output logic [6*rmj_pkg::FIELD_W-1:0]        m_axis_tdata,
  // too_close, saturated
  output logic [rmj_pkg::TUSER_W-1:0]          m_axis_tuser
);
  import rmj_pkg::*;

  localparam int NUM_R_W = FIELD_W + FRACTION_BITS;
  localparam int NUM_B_W = FIELD_W + 2 * FRACTION_BITS;
  localparam int NUM_C_W = PROD_W + FRACTION_BITS;
  localparam int R2H_W   = RAD_W - FRACTION_BITS;

  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;

  // Threshold register
  logic [FIELD_W-1:0] min_range_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_range_sq_q <= MIN_RANGE_SQ_RST;
    end else if (cfg_valid_i) begin
      min_range_sq_q <= cfg_data_i;
    end
  end

  // Stage 1: unpack the word and take magnitudes
  logic [FIELD_W-1:0] in_px, in_py;
  assign in_px = s_axis_tdata[FIELD_W-1:0];
  assign in_py = s_axis_tdata[2*FIELD_W-1:FIELD_W];

  logic                       s1_vld_q;
  logic [FIELD_W-1:0]         s1_apx_q, s1_apy_q;
  logic                       s1_npx_q, s1_npy_q;
  logic signed [FIELD_W-1:0]  s1_px_q, s1_py_q, s1_vx_q, s1_vy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_apx_q <= in_px[FIELD_W-1] ? (FIELD_W'(0) - in_px) : in_px;
      s1_apy_q <= in_py[FIELD_W-1] ? (FIELD_W'(0) - in_py) : in_py;
      s1_npx_q <= in_px[FIELD_W-1];
      s1_npy_q <= in_py[FIELD_W-1];
      s1_px_q  <= in_px;
      s1_py_q  <= in_py;
      s1_vx_q  <= s_axis_tdata[3*FIELD_W-1:2*FIELD_W];
      s1_vy_q  <= s_axis_tdata[4*FIELD_W-1:3*FIELD_W];
    end
  end

  // Stage 2: squares and cross products
  logic                        s2_vld_q;
  logic [2*FIELD_W-1:0]        s2_sqx_q, s2_sqy_q;
  logic signed [2*FIELD_W-1:0] s2_vp_q, s2_wp_q;
  logic [FIELD_W-1:0]          s2_apx_q, s2_apy_q;
  logic                        s2_npx_q, s2_npy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_sqx_q <= s1_apx_q * s1_apx_q;
      s2_sqy_q <= s1_apy_q * s1_apy_q;
      s2_vp_q  <= s1_vx_q * s1_py_q;
      s2_wp_q  <= s1_vy_q * s1_px_q;
      s2_apx_q <= s1_apx_q;
      s2_apy_q <= s1_apy_q;
      s2_npx_q <= s1_npx_q;
      s2_npy_q <= s1_npy_q;
    end
  end

  // Stage 3: r2, cross term, too-close test
  logic [RAD_W-1:0] r2_d;
  logic [C_W:0]     c_d;
  logic [R2H_W-1:0] r2_hi;

  assign r2_d  = s2_sqx_q + s2_sqy_q;
  assign c_d   = {s2_vp_q[2*FIELD_W-1], s2_vp_q} - {s2_wp_q[2*FIELD_W-1], s2_wp_q};
  assign r2_hi = r2_d[RAD_W-1:FRACTION_BITS];

  logic               s3_vld_q;
  logic [RAD_W-1:0]   s3_r2_q;
  logic [C_W:0]       s3_c_q;
  logic               s3_tc_q;
  logic [FIELD_W-1:0] s3_apx_q, s3_apy_q;
  logic               s3_npx_q, s3_npy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_r2_q  <= r2_d;
      s3_c_q   <= c_d;
      s3_tc_q  <= (r2_d == '0) || (r2_hi < R2H_W'(min_range_sq_q));
      s3_apx_q <= s2_apx_q;
      s3_apy_q <= s2_apy_q;
      s3_npx_q <= s2_npx_q;
      s3_npy_q <= s2_npy_q;
    end
  end

  // Stage 4: magnitude of the cross term, pack the sideband
  logic [C_W:0] c_neg;
  assign c_neg = (C_W + 1)'(0) - s3_c_q;

  logic      s4_vld_q;
  rmj_side_t s4_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (en) begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_side_q.apx <= s3_apx_q;
      s4_side_q.apy <= s3_apy_q;
      s4_side_q.npx <= s3_npx_q;
      s4_side_q.npy <= s3_npy_q;
      s4_side_q.r2  <= s3_r2_q;
      s4_side_q.ac  <= s3_c_q[C_W] ? c_neg[C_W-1:0] : s3_c_q[C_W-1:0];
      s4_side_q.nc  <= s3_c_q[C_W];
      s4_side_q.tc  <= s3_tc_q;
    end
  end

  // Square root of r2
  logic                         sq_vld;
  logic [ROOT_W-1:0]            sq_root;
  logic [$bits(rmj_side_t)-1:0] sq_sb;
  rmj_side_t                    sq_side;

  rmj_sqrt #(
    .SB_W ($bits(rmj_side_t))
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s4_vld_q),
    .rad_i  (s4_side_q.r2),
    .sb_i   (s4_side_q),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .sb_o   (sq_sb)
  );

  assign sq_side = rmj_side_t'(sq_sb);

  // Stage A: 32x32 partial products of r2*r and |p|*|c|
  logic                 sa_vld_q;
  rmj_side_t            sa_side_q;
  logic [ROOT_W-1:0]    sa_r_q;
  logic [2*FIELD_W-1:0] sa_r3l_q, sa_r3h_q, sa_yl_q, sa_yh_q, sa_xl_q, sa_xh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_vld_q <= 1'b0;
    end else if (en) begin
      sa_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_side_q <= sq_side;
      sa_r_q    <= sq_root;
      sa_r3l_q  <= sq_side.r2[FIELD_W-1:0] * sq_root;
      sa_r3h_q  <= sq_side.r2[RAD_W-1:FIELD_W] * sq_root;
      sa_yl_q   <= sq_side.ac[FIELD_W-1:0] * sq_side.apy;
      sa_yh_q   <= sq_side.ac[C_W-1:FIELD_W] * sq_side.apy;
      sa_xl_q   <= sq_side.ac[FIELD_W-1:0] * sq_side.apx;
      sa_xh_q   <= sq_side.ac[C_W-1:FIELD_W] * sq_side.apx;
    end
  end

  // Stage B: sum the partial products
  logic              sb_vld_q;
  rmj_side_t         sb_side_q;
  logic [ROOT_W-1:0] sb_r_q;
  logic [PROD_W-1:0] sb_r3_q, sb_py_q, sb_px_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_vld_q <= 1'b0;
    end else if (en) begin
      sb_vld_q <= sa_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_side_q <= sa_side_q;
      sb_r_q    <= sa_r_q;
      sb_r3_q   <= PROD_W'(sa_r3l_q) + {sa_r3h_q, {FIELD_W{1'b0}}};
      sb_py_q   <= PROD_W'(sa_yl_q) + {sa_yh_q, {FIELD_W{1'b0}}};
      sb_px_q   <= PROD_W'(sa_xl_q) + {sa_xh_q, {FIELD_W{1'b0}}};
    end
  end

  // Six quotients
  logic [Q_W-1:0] quo [6];
  logic [5:0]     sat;

  rmj_div #(.NUM_W(NUM_R_W), .DEN_W(ROOT_W)) u_div_rpx (
    .clk_i (clk_i), .en_i (en),
    .num_i ({sb_side_q.apx, {FRACTION_BITS{1'b0}}}),
    .den_i (sb_r_q), .neg_i (sb_side_q.npx),
    .quo_o (quo[0]), .sat_o (sat[0])
  );

  rmj_div #(.NUM_W(NUM_R_W), .DEN_W(ROOT_W)) u_div_rpy (
    .clk_i (clk_i), .en_i (en),
    .num_i ({sb_side_q.apy, {FRACTION_BITS{1'b0}}}),
    .den_i (sb_r_q), .neg_i (sb_side_q.npy),
    .quo_o (quo[1]), .sat_o (sat[1])
  );

  rmj_div #(.NUM_W(NUM_B_W), .DEN_W(RAD_W)) u_div_bpx (
    .clk_i (clk_i), .en_i (en),
    .num_i ({sb_side_q.apy, {(2 * FRACTION_BITS){1'b0}}}),
    .den_i (sb_side_q.r2), .neg_i (!sb_side_q.npy),
    .quo_o (quo[2]), .sat_o (sat[2])
  );

  rmj_div #(.NUM_W(NUM_B_W), .DEN_W(RAD_W)) u_div_bpy (
    .clk_i (clk_i), .en_i (en),
    .num_i ({sb_side_q.apx, {(2 * FRACTION_BITS){1'b0}}}),
    .den_i (sb_side_q.r2), .neg_i (sb_side_q.npx),
    .quo_o (quo[3]), .sat_o (sat[3])
  );

  rmj_div #(.NUM_W(NUM_C_W), .DEN_W(PROD_W)) u_div_tpx (
    .clk_i (clk_i), .en_i (en),
    .num_i ({sb_py_q, {FRACTION_BITS{1'b0}}}),
    .den_i (sb_r3_q), .neg_i (sb_side_q.npy != sb_side_q.nc),
    .quo_o (quo[4]), .sat_o (sat[4])
  );

  rmj_div #(.NUM_W(NUM_C_W), .DEN_W(PROD_W)) u_div_tpy (
    .clk_i (clk_i), .en_i (en),
    .num_i ({sb_px_q, {FRACTION_BITS{1'b0}}}),
    .den_i (sb_r3_q), .neg_i (sb_side_q.npx == sb_side_q.nc),
    .quo_o (quo[5]), .sat_o (sat[5])
  );

  // Carry valid and too-close alongside the dividers
  logic [DIV_LAT-1:0] dv_vld_q;
  logic [DIV_LAT-1:0] dv_tc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q <= '0;
    end else if (en) begin
      dv_vld_q <= {dv_vld_q[DIV_LAT-2:0], sb_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_tc_q <= {dv_tc_q[DIV_LAT-2:0], sb_side_q.tc};
    end
  end

  // Output register: zero the data and the saturation flag when too close
  logic tc_out;
  assign tc_out = dv_tc_q[DIV_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= dv_vld_q[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_axis_tdata <= tc_out ? '0 : {quo[5], quo[4], quo[3], quo[2], quo[1], quo[0]};
      m_axis_tuser[TU_TOO_CLOSE] <= tc_out;
      m_axis_tuser[TU_SAT]       <= !tc_out && (|sat);
    end
  end

endmodule

`default_nettype wire

// File: rtl/rmj_checker.sv
// ----------------------------------------------------------------------------
// rmj_checker
// Port-level checks of the radar Jacobian core, bound to every instance.
// ----------------------------------------------------------------------------
`default_nettype none

`include "radar_measurement_jacobian_core_macros.svh"

module rmj_checker #(
  parameter int FRACTION_BITS = 16
) (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            cfg_valid_i,
  input wire logic                            cfg_ready_o,
  input wire logic [rmj_pkg::FIELD_W-1:0]     cfg_data_i,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic [4*rmj_pkg::FIELD_W-1:0]   s_axis_tdata,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [6*rmj_pkg::FIELD_W-1:0]   m_axis_tdata,
  input wire logic [rmj_pkg::TUSER_W-1:0]     m_axis_tuser
);
  import rmj_pkg::*;

  localparam int RngMax = 1 << FRACTION_BITS;

  logic signed [FIELD_W-1:0] rng_px;
  logic                      tc;
  logic                      sat;
  logic                      cfg_seen;
  logic                      in_seen;

  assign rng_px   = m_axis_tdata[FIELD_W-1:0];
  assign tc       = m_axis_tuser[TU_TOO_CLOSE];
  assign sat      = m_axis_tuser[TU_SAT];
  assign cfg_seen = cfg_valid_i && cfg_ready_o;
  assign in_seen  = s_axis_tvalid && (|s_axis_tdata || !(|cfg_data_i) || cfg_seen);

  // Too close: every derivative is zero and nothing clipped
  `RMJ_ASSERT_NOW(a_close_zero, clk_i, rst_ni, m_axis_tvalid && tc, (m_axis_tdata == '0) && !sat)

  // Empty output register never blocks the input side
  `RMJ_ASSERT_NOW(a_ready_empty, clk_i, rst_ni, !m_axis_tvalid || in_seen, !m_axis_tvalid -> s_axis_tready)

  // px / r never exceeds one in magnitude
  `RMJ_ASSERT_NOW(a_range_unit, clk_i, rst_ni, m_axis_tvalid && !tc, (rng_px <= RngMax) && (rng_px >= -RngMax))

  // A stalled result holds
  `RMJ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind radar_measurement_jacobian_core rmj_checker #(
  .FRACTION_BITS (FRACTION_BITS)
) u_rmj_checker (.*);

`default_nettype wire
